/* src/tte_pkg.sv */
package tte_pkg;

  // Final-result status codes
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOT_INT      = 3'd1,
    ST_RANGE        = 3'd2,
    ST_NEG_UNSIGNED = 3'd3,
    ST_BAD_HEX      = 3'd4,
    ST_ODD_HEX      = 3'd5
  } status_e;

  // Integer parse phase, one-hot
  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_e;

  // Type code for hex byte strings; codes below eight are integers
  localparam logic [3:0] TYPE_BYTES = 4'd9;

  // Characters of interest
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // Per-value parse state
  typedef struct packed {
    logic [63:0] mag;
    logic        neg;
    phase_e      phase;
    logic        hex;
    logic        digit_seen;
    status_e     err;
    logic [3:0]  nib;
    logic        nib_pend;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    mag:        64'd0,
    neg:        1'b0,
    phase:      PH_START,
    hex:        1'b0,
    digit_seen: 1'b0,
    err:        ST_OK,
    nib:        4'd0,
    nib_pend:   1'b0
  };

  // What one character step produces
  typedef struct packed {
    logic       gen;      // a result is produced now
    logic [7:0] data;
    logic       dvalid;
    logic       last;
    status_e    status;
    logic       int_end;  // integer value closed, encode next cycle
  } step_res_t;

endpackage

/* src/tte_char_step.sv */
module tte_char_step (
  input  tte_pkg::parse_state_t state_i,
  input  logic [3:0]            type_i,
  input  logic [7:0]            char_i,
  input  logic                  char_valid_i,
  input  logic                  last_i,
  output tte_pkg::parse_state_t state_o,
  output tte_pkg::step_res_t    res_o
);
  import tte_pkg::*;

  // Digit value with a valid flag in the top bit
  function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, 4'(c - CH_ZERO)};
    end else if (hex && c >= CH_LOW_A && c <= CH_LOW_F) begin
      r = {1'b1, 4'(c - CH_LOW_A + 8'd10)};
    end else if (hex && c >= CH_UP_A && c <= CH_UP_F) begin
      r = {1'b1, 4'(c - CH_UP_A + 8'd10)};
    end
    return r;
  endfunction

  logic [4:0]  int_dig;
  logic [4:0]  hex_dig;
  logic [67:0] mac;
  logic        skip_sep;

  // Multiply-accumulate by ten or sixteen; carry beyond bit 63 is overflow
  assign int_dig = digit_of(char_i, state_i.hex);
  assign hex_dig = digit_of(char_i, 1'b1);
  always_comb begin
    if (state_i.hex) begin
      mac = {state_i.mag, 4'd0} + {64'd0, int_dig[3:0]};
    end else begin
      mac = {1'b0, state_i.mag, 3'd0} + {3'd0, state_i.mag, 1'b0}
          + {64'd0, int_dig[3:0]};
    end
  end

  assign skip_sep = (char_i == CH_SPACE) || (char_i == CH_COLON) || (char_i == CH_COMMA);

  always_comb begin
    state_o = state_i;
    res_o   = '{gen: 1'b0, data: 8'd0, dvalid: 1'b0, last: 1'b0,
                status: ST_OK, int_end: 1'b0};

    if (type_i[3] == 1'b0) begin
      // Integer text
      if (char_valid_i && state_i.err == ST_OK) begin
        if (state_i.phase == PH_START && (char_i == CH_MINUS || char_i == CH_PLUS)) begin
          state_o.neg   = (char_i == CH_MINUS);
          state_o.phase = PH_SIGN;
        end else if ((state_i.phase == PH_START || state_i.phase == PH_SIGN)
                     && char_i == CH_ZERO) begin
          state_o.phase      = PH_ZERO;
          state_o.mag        = 64'd0;
          state_o.digit_seen = 1'b1;
        end else if (state_i.phase == PH_ZERO && (char_i == CH_LOW_X || char_i == CH_UP_X)) begin
          state_o.hex        = 1'b1;
          state_o.digit_seen = 1'b0;
          state_o.mag        = 64'd0;
          state_o.phase      = PH_DIGITS;
        end else begin
          state_o.phase = PH_DIGITS;
          if (!int_dig[4] || mac[67:64] != 4'd0) begin
            state_o.err = ST_NOT_INT;
          end else begin
            state_o.mag        = mac[63:0];
            state_o.digit_seen = 1'b1;
          end
        end
      end
      res_o.int_end = last_i;
    end else if (type_i == TYPE_BYTES) begin
      // Hex byte string
      if (char_valid_i && state_i.err == ST_OK && !skip_sep) begin
        if (!hex_dig[4]) begin
          state_o.err = ST_BAD_HEX;
        end else if (state_i.nib_pend) begin
          res_o.gen      = 1'b1;
          res_o.data     = {state_i.nib, hex_dig[3:0]};
          res_o.dvalid   = 1'b1;
          res_o.last     = last_i;
          state_o.nib      = 4'd0;
          state_o.nib_pend = 1'b0;
        end else begin
          state_o.nib      = hex_dig[3:0];
          state_o.nib_pend = 1'b1;
        end
      end
      if (last_i) begin
        if (!res_o.gen) begin
          res_o.gen    = 1'b1;
          res_o.last   = 1'b1;
          res_o.status = (state_o.err == ST_OK && state_o.nib_pend) ? ST_ODD_HEX
                                                                    : state_o.err;
        end
        state_o = STATE_CLEAR;
      end
    end else begin
      // String and unused codes pass through
      if (char_valid_i) begin
        res_o.gen    = 1'b1;
        res_o.data   = char_i;
        res_o.dvalid = 1'b1;
        res_o.last   = last_i;
      end else if (last_i) begin
        res_o.gen  = 1'b1;
        res_o.last = 1'b1;
      end
      if (last_i) begin
        state_o = STATE_CLEAR;
      end
    end
  end

endmodule

/* src/typed_text_value_encoder.sv */
// A character's result passes through the input register and then the output register.
// An integer's closing item passes through the input register, end_pend_q and the burst registers to
// the output register, then one byte a cycle while the output accepts. Throughput: one character per
// cycle unless the output stalls; an integer close holds the input through the encode step and burst.
// Reset: rst_ni is asynchronous, active low, and clears parse state and all valid flags.
module typed_text_value_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic [4:0] s_axis_tuser,   // [3:0] value_type, [4] char_valid
  input  logic       s_axis_tlast,   // last_char
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_byte
  output logic [3:0] m_axis_tuser,   // [0] data_valid, [3:1] status
  output logic       m_axis_tlast    // end_of_value
);
  import tte_pkg::*;

  // Input register
  logic       in_valid_q;
  logic [3:0] in_type_q;
  logic [7:0] in_char_q;
  logic       in_cv_q;
  logic       in_last_q;

  // Parse state and closing burst
  parse_state_t state_q, state_d, step_state;
  step_res_t    step_res;
  logic         end_pend_q;
  logic [3:0]   end_type_q;
  logic [63:0]  burst_data_q;
  logic [3:0]   burst_left_q;
  status_e      burst_err_q;

  // Output register
  logic         out_valid_q;
  logic [7:0]   out_data_q;
  logic         out_dv_q;
  logic         out_last_q;
  status_e      out_status_q;

  logic         out_free;
  logic         busy;
  logic         consume;
  logic         s_fire;
  logic         burst_emit;

  tte_char_step u_step (
    .state_i      (state_q),
    .type_i       (in_type_q),
    .char_i       (in_char_q),
    .char_valid_i (in_cv_q),
    .last_i       (in_last_q),
    .state_o      (step_state),
    .res_o        (step_res)
  );

  assign out_free   = !out_valid_q || m_axis_tready;
  assign busy       = end_pend_q || (burst_left_q != 4'd0);
  assign consume    = in_valid_q && !busy && (!step_res.gen || out_free);
  assign s_axis_tready = !in_valid_q || consume;
  assign s_fire     = s_axis_tvalid && s_axis_tready;
  assign burst_emit = (burst_left_q != 4'd0) && out_free;

  // Range check and two's complement at the close of an integer
  logic [63:0] max_pos, max_uns, max_neg, enc_val;
  status_e     enc_err;
  logic [3:0]  enc_count;
  always_comb begin
    case (end_type_q[2:1])
      2'd0: begin
        max_pos = 64'h0000_0000_0000_007F;
        max_uns = 64'h0000_0000_0000_00FF;
      end
      2'd1: begin
        max_pos = 64'h0000_0000_0000_7FFF;
        max_uns = 64'h0000_0000_0000_FFFF;
      end
      2'd2: begin
        max_pos = 64'h0000_0000_7FFF_FFFF;
        max_uns = 64'h0000_0000_FFFF_FFFF;
      end
      default: begin
        max_pos = 64'h7FFF_FFFF_FFFF_FFFF;
        max_uns = 64'hFFFF_FFFF_FFFF_FFFF;
      end
    endcase
    max_neg   = max_pos + 64'd1;
    enc_val   = state_q.mag;
    enc_err   = state_q.err;
    enc_count = 4'd1 << end_type_q[2:1];
    if (enc_err == ST_OK && !state_q.digit_seen) begin
      enc_err = ST_NOT_INT;
    end
    if (enc_err == ST_OK) begin
      if (end_type_q[0]) begin
        if ((state_q.neg && state_q.mag > max_neg) || (!state_q.neg && state_q.mag > max_pos)) begin
          enc_err = ST_RANGE;
        end else if (state_q.neg) begin
          enc_val = ~state_q.mag + 64'd1;
        end
      end else if (state_q.neg) begin
        enc_err = ST_NEG_UNSIGNED;
      end else if (state_q.mag > max_uns) begin
        enc_err = ST_RANGE;
      end
    end
    if (enc_err != ST_OK) begin
      enc_count = 4'd1;
    end
  end

  // Next parse state: step on transfer, clear once the integer is encoded
  always_comb begin
    state_d = state_q;
    if (end_pend_q) begin
      state_d = STATE_CLEAR;
    end else if (consume) begin
      state_d = step_state;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      state_q      <= STATE_CLEAR;
      end_pend_q   <= 1'b0;
      burst_left_q <= 4'd0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      end_pend_q <= consume && step_res.int_end;
      if (end_pend_q) begin
        burst_left_q <= enc_count;
      end else if (burst_emit) begin
        burst_left_q <= burst_left_q - 4'd1;
      end
      if (burst_emit || (consume && step_res.gen)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_type_q <= s_axis_tuser[3:0];
      in_char_q <= s_axis_tdata;
      in_cv_q   <= s_axis_tuser[4];
      in_last_q <= s_axis_tlast;
    end
    if (consume && step_res.int_end) begin
      end_type_q <= in_type_q;
    end
    if (end_pend_q) begin
      burst_data_q <= enc_val;
      burst_err_q  <= enc_err;
    end else if (burst_emit) begin
      burst_data_q <= {8'd0, burst_data_q[63:8]};
    end
    if (burst_emit) begin
      if (burst_err_q != ST_OK) begin
        out_data_q   <= 8'd0;
        out_dv_q     <= 1'b0;
        out_last_q   <= 1'b1;
        out_status_q <= burst_err_q;
      end else begin
        out_data_q   <= burst_data_q[7:0];
        out_dv_q     <= 1'b1;
        out_last_q   <= (burst_left_q == 4'd1);
        out_status_q <= ST_OK;
      end
    end else if (consume && step_res.gen) begin
      out_data_q   <= step_res.data;
      out_dv_q     <= step_res.dvalid;
      out_last_q   <= step_res.last;
      out_status_q <= step_res.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {out_status_q, out_dv_q};
  assign m_axis_tlast  = out_last_q;

  // An integer close always loads a burst of at least one result
  a_burst_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_pend_q |=> (burst_left_q != 4'd0))
    else $error("integer close did not load a burst");

  // An error burst carries a single result
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((burst_left_q != 4'd0) && (burst_err_q != ST_OK)) |-> (burst_left_q == 4'd1))
    else $error("error burst longer than one result");

  // Non-final results carry no status
  a_status_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser[3:1] == ST_OK))
    else $error("status on a non-final result");

  // No new item is taken from the input register during a close
  a_hold_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !consume)
    else $error("item processed during integer close");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import tte_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 500;
  localparam int TAIL_CYCLES  = 20;

  // Value type codes
  localparam logic [3:0] TY_U8     = 4'd0;
  localparam logic [3:0] TY_I8     = 4'd1;
  localparam logic [3:0] TY_U16    = 4'd2;
  localparam logic [3:0] TY_I64    = 4'd7;
  localparam logic [3:0] TY_STRING = 4'd8;
  localparam logic [3:0] TY_TOP    = 4'd15;

  // One encoded output byte with its flags
  typedef struct packed {
    logic [7:0] data;
    logic       dvalid;
    logic       eov;
    status_e    st;
  } enc_byte_t;

  // One input character, optionally with a hand-written result
  typedef struct packed {
    logic [3:0] vtype;
    logic [7:0] ch;
    logic       cv;
    logic       last;
    logic       fixed;    // want replaces the prediction
    logic       fixed_n;  // 0: no result, 1: one result
    enc_byte_t  want;
  } char_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] char_code
  logic [4:0] s_axis_tuser;   // [3:0] value_type, [4] char_valid
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] data_byte
  logic [3:0] m_axis_tuser;   // [0] data_valid, [3:1] status
  logic       m_axis_tlast;

  // Predicted parse state
  logic [63:0] acc_mag;
  logic        acc_neg;
  phase_e      acc_phase;
  logic        acc_hex;
  logic        acc_seen;
  status_e     acc_err;
  logic [3:0]  acc_nib;
  logic        acc_nib_wait;

  enc_byte_t   pending_bytes[$];
  enc_byte_t   step_bytes[$];
  char_item_t  dir_rows[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int          items_sent = 0;
  logic        send_quiet = 1'b0;
  logic        recv_quiet = 1'b0;

  typed_text_value_encoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic enc_byte_t enc(logic [7:0] data, logic dvalid, logic eov, status_e st);
    enc_byte_t b;
    b.data   = data;
    b.dvalid = dvalid;
    b.eov    = eov;
    b.st     = st;
    return b;
  endfunction

  // Empty final result carrying only the status
  function automatic enc_byte_t closing(status_e st);
    return enc(8'h00, 1'b0, 1'b1, st);
  endfunction

  // Append one predicted byte for the current character
  function automatic void add_step(enc_byte_t b);
    step_bytes.insert(step_bytes.size(), b);
  endfunction

  // Append one row to the directed table
  function automatic void add_row(char_item_t it);
    dir_rows.insert(dir_rows.size(), it);
  endfunction

  function automatic string describe(enc_byte_t b);
    return $sformatf("byte %02h valid %0b end %0b status %0d", b.data, b.dvalid, b.eov, b.st);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $time, what);
    fail_count++;
  endtask

  // Alternate between stretches without idling and random waits
  function automatic int draw_wait(inout logic quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : int'($urandom_range(0, 19));
  endfunction

  function automatic void clear_parse();
    acc_mag      = '0;
    acc_neg      = 1'b0;
    acc_phase    = PH_START;
    acc_hex      = 1'b0;
    acc_seen     = 1'b0;
    acc_err      = ST_OK;
    acc_nib      = '0;
    acc_nib_wait = 1'b0;
  endfunction

  function automatic int digit_value(logic [7:0] c, logic hex);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (hex && c >= CH_LOW_A && c <= CH_LOW_F) return int'(c - CH_LOW_A) + 10;
    if (hex && c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
    return -1;
  endfunction

  // Accumulate one digit, latching an error on a bad digit or overflow
  function automatic void add_digit(logic [7:0] c);
    int          d;
    logic [63:0] base;
    d = digit_value(c, acc_hex);
    base = acc_hex ? 64'd16 : 64'd10;
    acc_phase = PH_DIGITS;
    if (d < 0) begin
      acc_err = ST_NOT_INT;
      return;
    end
    if (acc_mag > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / base) begin
      acc_err = ST_NOT_INT;
      return;
    end
    acc_mag = acc_mag * base + 64'(d);
    acc_seen = 1'b1;
  endfunction

  function automatic void int_char(logic [7:0] c);
    if (acc_err != ST_OK) return;
    if (acc_phase == PH_START && (c == CH_MINUS || c == CH_PLUS)) begin
      acc_neg = (c == CH_MINUS);
      acc_phase = PH_SIGN;
      return;
    end
    if (acc_phase == PH_START || acc_phase == PH_SIGN) begin
      if (c == CH_ZERO) begin
        acc_phase = PH_ZERO;
        acc_mag = '0;
        acc_seen = 1'b1;
      end else begin
        add_digit(c);
      end
      return;
    end
    if (acc_phase == PH_ZERO && (c == CH_LOW_X || c == CH_UP_X)) begin
      acc_hex = 1'b1;
      acc_seen = 1'b0;
      acc_mag = '0;
      acc_phase = PH_DIGITS;
      return;
    end
    add_digit(c);
  endfunction

  // Range check and little-endian two's complement bytes at integer end
  function automatic void int_close(logic [3:0] vtype);
    int unsigned width;
    int unsigned bits;
    int unsigned i;
    logic [63:0] v;
    logic [63:0] lim;
    logic [63:0] top_pos;
    width = 1 << vtype[2:1];
    bits = width * 8;
    lim = (bits == 64) ? '1 : (64'd1 << bits) - 64'd1;
    top_pos = lim >> 1;
    v = acc_mag;
    if (acc_err == ST_OK && !acc_seen) acc_err = ST_NOT_INT;
    if (acc_err == ST_OK) begin
      if (vtype[0]) begin
        if (acc_neg ? (v > top_pos + 64'd1) : (v > top_pos)) acc_err = ST_RANGE;
        else if (acc_neg) v = ~v + 64'd1;
      end else if (acc_neg) begin
        acc_err = ST_NEG_UNSIGNED;
      end else if (v > lim) begin
        acc_err = ST_RANGE;
      end
    end
    if (acc_err != ST_OK) begin
      add_step(closing(acc_err));
    end else begin
      for (i = 0; i < width; i++)
        add_step(enc(v[8*i +: 8], 1'b1, i == width - 1, ST_OK));
    end
  endfunction

  // Predict the bytes caused by one accepted character
  function automatic void encode_char(logic [3:0] vtype, logic [7:0] ch, logic cv, logic last);
    int        d;
    logic      held;
    enc_byte_t b;
    step_bytes.delete();
    held = 1'b0;
    b = closing(ST_OK);
    if (!vtype[3]) begin
      if (cv) int_char(ch);
      if (last) begin
        int_close(vtype);
        clear_parse();
      end
    end else if (vtype == TYPE_BYTES) begin
      if (cv && acc_err == ST_OK && ch != CH_SPACE && ch != CH_COLON && ch != CH_COMMA) begin
        d = digit_value(ch, 1'b1);
        if (d < 0) begin
          acc_err = ST_BAD_HEX;
        end else if (acc_nib_wait) begin
          b = enc({acc_nib, 4'(d)}, 1'b1, 1'b0, ST_OK);
          held = 1'b1;
          acc_nib_wait = 1'b0;
          acc_nib = '0;
        end else begin
          acc_nib = 4'(d);
          acc_nib_wait = 1'b1;
        end
      end
      if (last) begin
        if (acc_err == ST_OK && acc_nib_wait) acc_err = ST_ODD_HEX;
        if (acc_err == ST_OK && held) begin
          b.eov = 1'b1;
        end else begin
          if (held) add_step(b);
          b = closing(acc_err);
          held = 1'b1;
        end
        clear_parse();
      end
      if (held) add_step(b);
    end else begin
      if (cv) add_step(enc(ch, 1'b1, last, ST_OK));
      else if (last) add_step(closing(ST_OK));
      if (last) clear_parse();
    end
  endfunction

  function automatic char_item_t plain(logic [3:0] vt, logic [7:0] c, logic cv, logic last);
    char_item_t it;
    it = '0;
    it.vtype = vt;
    it.ch    = c;
    it.cv    = cv;
    it.last  = last;
    return it;
  endfunction

  function automatic char_item_t known(logic [3:0] vt, logic [7:0] c, logic cv, logic last,
                                       logic n, enc_byte_t want);
    char_item_t it;
    it = plain(vt, c, cv, last);
    it.fixed   = 1'b1;
    it.fixed_n = n;
    it.want    = want;
    return it;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib, logic upper);
    if (nib < 10) return CH_ZERO + 8'(nib);
    return (upper ? CH_UP_A : CH_LOW_A) + 8'(nib - 10);
  endfunction

  // Offer one character, wait for its transfer, then queue what it should cause
  task automatic send_char(input char_item_t it);
    int gap;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it.ch;
    s_axis_tuser  <= {it.cv, it.vtype};
    s_axis_tlast  <= it.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    encode_char(it.vtype, it.ch, it.cv, it.last);
    if (it.fixed) begin
      step_bytes.delete();
      if (it.fixed_n) add_step(it.want);
    end
    foreach (step_bytes[k]) pending_bytes.insert(pending_bytes.size(), step_bytes[k]);
  endtask

  // Hold the input off until every queued byte has left
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  // Build and send one value: mostly well-formed text, some broken or noise
  task automatic random_value();
    logic [3:0]  vt;
    logic [7:0]  txt[$];
    logic [63:0] mag;
    logic [63:0] lim;
    int unsigned pick;
    int unsigned bits;
    int unsigned n;
    logic        hex;
    logic        upper;
    logic        close_empty;
    char_item_t  it;
    pick = $urandom_range(0, 99);
    upper = 1'($urandom_range(0, 1));
    if (pick < 55) begin
      vt = 4'($urandom_range(TY_U8, TY_I64));
      bits = 8 << vt[2:1];
      lim = (bits == 64) ? '1 : (64'd1 << bits) - 64'd1;
      case ($urandom_range(0, 8))
        0: mag = '0;
        1: mag = 64'($urandom_range(0, 20));
        2: mag = lim >> 1;
        3: mag = (lim >> 1) + 64'd1;
        4: mag = (lim >> 1) + 64'd2;
        5: mag = lim;
        6: mag = lim + 64'd1;
        7: mag = {$urandom, $urandom} & lim;
        default: mag = {$urandom, $urandom};
      endcase
      hex = ($urandom_range(0, 2) == 0);
      // digits, most significant pushed last to the front
      do begin
        if (hex) begin
          txt.push_front(hex_char(mag[3:0], upper));
          mag = mag >> 4;
        end else begin
          txt.push_front(8'(CH_ZERO + mag % 10));
          mag = mag / 10;
        end
      end while (mag != 0);
      if ($urandom_range(0, 7) == 0) txt.push_front(CH_ZERO);
      if ($urandom_range(0, 15) == 0) txt.insert(txt.size(), hex ? CH_UP_F : CH_NINE);
      if (hex) begin
        txt.push_front(upper ? CH_UP_X : CH_LOW_X);
        txt.push_front(CH_ZERO);
      end
      case ($urandom_range(0, 3))
        0: txt.push_front(CH_MINUS);
        1: txt.push_front(CH_PLUS);
        default: ;
      endcase
      if ($urandom_range(0, 11) == 0) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom);
      if ($urandom_range(0, 29) == 0) txt.delete();
    end else if (pick < 70) begin
      vt = (pick < 64) ? TY_STRING : 4'($urandom_range(10, TY_TOP));
      n = $urandom_range(0, 6);
      repeat (n) txt.insert(txt.size(), 8'($urandom));
    end else if (pick < 93) begin
      vt = TYPE_BYTES;
      n = $urandom_range(0, 4);
      repeat (n) begin
        txt.insert(txt.size(), hex_char(4'($urandom), 1'($urandom)));
        txt.insert(txt.size(), hex_char(4'($urandom), 1'($urandom)));
        case ($urandom_range(0, 5))
          0: txt.insert(txt.size(), CH_SPACE);
          1: txt.insert(txt.size(), CH_COLON);
          2: txt.insert(txt.size(), CH_COMMA);
          default: ;
        endcase
      end
      if ($urandom_range(0, 7) == 0) txt.insert(txt.size(), hex_char(4'($urandom), upper));
      if (txt.size() != 0 && $urandom_range(0, 9) == 0)
        txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom);
    end else begin
      vt = 4'($urandom);
      n = $urandom_range(0, 5);
      repeat (n) txt.insert(txt.size(), 8'($urandom));
    end

    close_empty = (txt.size() == 0) || ($urandom_range(0, 3) == 0);
    foreach (txt[i]) begin
      // filler characters that the block drops
      if ($urandom_range(0, 19) == 0)
        send_char(plain(4'($urandom), 8'($urandom), 1'b0, 1'b0));
      it = plain(vt, txt[i], 1'b1, !close_empty && i == txt.size() - 1);
      // switch the type for a single character now and then
      if ($urandom_range(0, 29) == 0) it.vtype = 4'($urandom);
      send_char(it);
      items_sent++;
    end
    if (close_empty) begin
      send_char(plain(vt, 8'($urandom), 1'b0, 1'b1));
      items_sent++;
    end
  endtask

  // Output side: random stalls, compare each transfer with the oldest prediction
  initial begin
    int        stall;
    enc_byte_t got;
    enc_byte_t want;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait(recv_quiet);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got = enc(m_axis_tdata, m_axis_tuser[0], m_axis_tlast, status_e'(m_axis_tuser[3:1]));
      if (pending_bytes.size() == 0) begin
        report_mismatch({"unexpected ", describe(got)});
      end else begin
        want = pending_bytes.pop_front();
        if (got !== want)
          report_mismatch({"got ", describe(got), ", want ", describe(want)});
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("typed_text_value_encoder verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic       mid_drained;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    mid_drained = 1'b0;
    clear_parse();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // negative zero into an unsigned type
    add_row(plain(TY_U8, CH_MINUS, 1'b1, 1'b0));
    add_row(known(TY_U8, CH_ZERO, 1'b1, 1'b1, 1'b1, closing(ST_NEG_UNSIGNED)));
    // lone sign
    add_row(known(TY_I8, CH_MINUS, 1'b1, 1'b1, 1'b1, closing(ST_NOT_INT)));
    // empty text closed by an empty item
    add_row(known(TY_U16, 8'h00, 1'b0, 1'b1, 1'b1, closing(ST_NOT_INT)));
    // bare hex prefix
    add_row(plain(TY_I64, CH_ZERO, 1'b1, 1'b0));
    add_row(known(TY_I64, CH_LOW_X, 1'b1, 1'b1, 1'b1, closing(ST_NOT_INT)));
    // one above the signed byte maximum
    add_row(plain(TY_I8, "1", 1'b1, 1'b0));
    add_row(plain(TY_I8, "2", 1'b1, 1'b0));
    add_row(known(TY_I8, "8", 1'b1, 1'b1, 1'b1, closing(ST_RANGE)));
    // signed byte minimum in hex
    add_row(plain(TY_I8, CH_MINUS, 1'b1, 1'b0));
    add_row(plain(TY_I8, CH_ZERO, 1'b1, 1'b0));
    add_row(plain(TY_I8, CH_UP_X, 1'b1, 1'b0));
    add_row(plain(TY_I8, "8", 1'b1, 1'b0));
    add_row(plain(TY_I8, "0", 1'b1, 1'b1));
    // a non-digit latches the error, later digits are ignored
    add_row(plain(TY_I64 - 4'd1, "z", 1'b1, 1'b0));
    add_row(known(TY_I64 - 4'd1, "5", 1'b1, 1'b1, 1'b1, closing(ST_NOT_INT)));
    // hex pair split by a separator
    add_row(plain(TYPE_BYTES, "A", 1'b1, 1'b0));
    add_row(plain(TYPE_BYTES, CH_COLON, 1'b1, 1'b0));
    add_row(plain(TYPE_BYTES, "f", 1'b1, 1'b1));
    // bad hex wins over a dangling nibble
    add_row(plain(TYPE_BYTES, "1", 1'b1, 1'b0));
    add_row(known(TYPE_BYTES, "g", 1'b1, 1'b1, 1'b1, closing(ST_BAD_HEX)));
    // odd number of hex digits
    add_row(known(TYPE_BYTES, "3", 1'b1, 1'b1, 1'b1, closing(ST_ODD_HEX)));
    // top character passes through a string
    add_row(known(TY_STRING, 8'hFF, 1'b1, 1'b1, 1'b1, enc(8'hFF, 1'b1, 1'b1, ST_OK)));
    // unassigned type code behaves as string: empty close
    add_row(known(TY_TOP, 8'h00, 1'b0, 1'b1, 1'b1, closing(ST_OK)));
    // empty non-closing item causes nothing
    add_row(known(TY_STRING, 8'h55, 1'b0, 1'b0, 1'b0, closing(ST_OK)));

    foreach (dir_rows[i]) send_char(dir_rows[i]);
    drain();

    while (items_sent < RANDOM_ITEMS) begin
      random_value();
      if (!mid_drained && items_sent >= RANDOM_ITEMS / 2) begin
        drain();
        mid_drained = 1'b1;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("typed_text_value_encoder verification clean");
    end else begin
      $display("typed_text_value_encoder verification failed");
    end
    $finish;
  end

endmodule
